// ----- design/tta_pkg.sv -----
// shared types, constants and helpers of the texel address pipeline
package tta_pkg;

  localparam int CW = 24;      // coordinate width
  localparam int SW = 13;      // texture size register width
  localparam int TW = 12;      // texel index width
  localparam int DW = CW + 1;  // numerator and divisor width
  localparam int MW = DW + SW; // product width

  localparam logic OP_FLAT = 1'b0;
  localparam logic OP_CUBE = 1'b1;

  localparam logic MODE_CLAMP = 1'b0;
  localparam logic MODE_WRAP  = 1'b1;

  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_NEG_Z = 3'd4;
  localparam logic [2:0] FACE_POS_Z = 3'd5;

  typedef struct packed {
    logic                 op;
    logic signed [CW-1:0] coord_a;
    logic signed [CW-1:0] coord_b;
    logic signed [CW-1:0] coord_c;
  } tta_req_t;

  typedef struct packed {
    logic [2:0]    cube_face;
    logic [TW-1:0] texel_x;
    logic [TW-1:0] texel_y;
    logic          zero_vector;
  } tta_rsp_t;

  // per request control travelling with the data
  typedef struct packed {
    logic       op;
    logic [2:0] face;
    logic       zero;
    logic       neg_x;
    logic       neg_y;
  } tta_side_t;

  // effective sizes and address modes
  typedef struct packed {
    logic [SW-1:0] width;
    logic [SW-1:0] height;
    logic          mode_x;
    logic          mode_y;
  } tta_cfg_t;

  // magnitude plus or minus a component, floored at zero
  function automatic logic [DW-1:0] proj_num(logic [CW-1:0] mag, logic [CW-1:0] a,
                                             logic pos);
    logic [CW+1:0] ext;
    logic [CW+1:0] s;
    ext = {{2{a[CW-1]}}, a};
    s = {2'b00, mag} + (pos ? ext : (~ext + 1'b1));
    return s[CW+1] ? '0 : s[DW-1:0];
  endfunction

endpackage

// ----- design/tta_front.sv -----
// front stages: major axis, face, numerators, then the size multiply
module tta_front #(
  parameter int FRAC_BITS = 16,
  parameter int XW        = 45
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tta_pkg::tta_req_t   req_i,
  input  tta_pkg::tta_cfg_t   cfg_i,
  output logic                valid_o,
  output tta_pkg::tta_side_t  side_o,
  output logic [XW-1:0]       nx_o,
  output logic [XW-1:0]       ny_o,
  output logic [tta_pkg::DW-1:0] dx_o,
  output logic [tta_pkg::DW-1:0] dy_o
);
  import tta_pkg::*;

  logic [CW-1:0] ax, ay, az, mag;
  tta_side_t     side;
  logic [DW-1:0] opx, opy, divx, divy;

  logic          s1_valid_q;
  tta_side_t     s1_side_q;
  logic [DW-1:0] s1_ax_q, s1_ay_q, s1_dx_q, s1_dy_q;
  logic [MW-1:0] prod_x, prod_y;
  logic [XW-1:0] nx_d, ny_d;

  // stage one: magnitudes, major axis and projection numerators
  always_comb begin
    ax = req_i.coord_a[CW-1] ? (~req_i.coord_a + 1'b1) : req_i.coord_a;
    ay = req_i.coord_b[CW-1] ? (~req_i.coord_b + 1'b1) : req_i.coord_b;
    az = req_i.coord_c[CW-1] ? (~req_i.coord_c + 1'b1) : req_i.coord_c;
    side.op    = req_i.op;
    side.zero  = 1'b0;
    side.face  = FACE_POS_X;
    side.neg_x = req_i.coord_a[CW-1];
    side.neg_y = req_i.coord_b[CW-1];
    mag  = ax;
    opx  = {1'b0, ax};
    opy  = {1'b0, ay};
    divx = {{(DW-SW){1'b0}}, cfg_i.width};
    divy = {{(DW-SW){1'b0}}, cfg_i.height};
    if (req_i.op == OP_CUBE) begin
      side.zero = (ax == '0) && (ay == '0) && (az == '0);
      if (ax >= ay && ax >= az) begin
        mag = ax;
        side.face = $signed(req_i.coord_a) > 0 ? FACE_POS_X : FACE_NEG_X;
        opx = proj_num(ax, req_i.coord_c, side.face == FACE_POS_X);
        opy = proj_num(ax, req_i.coord_b, 1'b0);
      end else if (ay >= az) begin
        mag = ay;
        side.face = $signed(req_i.coord_b) > 0 ? FACE_POS_Y : FACE_NEG_Y;
        opx = proj_num(ay, req_i.coord_a, 1'b1);
        opy = proj_num(ay, req_i.coord_c, side.face != FACE_POS_Y);
      end else begin
        mag = az;
        side.face = $signed(req_i.coord_c) > 0 ? FACE_POS_Z : FACE_NEG_Z;
        opx = proj_num(az, req_i.coord_a, side.face != FACE_POS_Z);
        opy = proj_num(az, req_i.coord_b, 1'b0);
      end
      divx = {mag, 1'b0};
      divy = {mag, 1'b0};
    end
  end

  // stage two: scale by texture size, flat requests drop the fraction
  always_comb begin
    prod_x = MW'(s1_ax_q) * MW'(s1_dx_q == '0 ? cfg_i.width : cfg_i.width);
    prod_y = MW'(s1_ay_q) * MW'(cfg_i.height);
    if (s1_side_q.op == OP_CUBE) begin
      nx_d = XW'(prod_x);
      ny_d = XW'(prod_y);
    end else begin
      nx_d = XW'(prod_x >> FRAC_BITS);
      ny_d = XW'(prod_y >> FRAC_BITS);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      valid_o    <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      valid_o    <= s1_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_side_q <= side;
      s1_ax_q   <= opx;
      s1_ay_q   <= opy;
      s1_dx_q   <= divx;
      s1_dy_q   <= divy;
      side_o    <= s1_side_q;
      nx_o      <= nx_d;
      ny_o      <= ny_d;
      dx_o      <= s1_dx_q;
      dy_o      <= s1_dy_q;
    end
  end

endmodule

// ----- design/tta_div_step.sv -----
// one restoring division step for both axes
module tta_div_step #(
  parameter int XW  = 45,
  parameter int QW  = 20,
  parameter int BIT = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  tta_pkg::tta_side_t     side_i,
  input  logic [XW-1:0]          rx_i,
  input  logic [XW-1:0]          ry_i,
  input  logic [tta_pkg::DW-1:0] dx_i,
  input  logic [tta_pkg::DW-1:0] dy_i,
  input  logic [QW-1:0]          qx_i,
  input  logic [QW-1:0]          qy_i,
  output logic                   valid_o,
  output tta_pkg::tta_side_t     side_o,
  output logic [XW-1:0]          rx_o,
  output logic [XW-1:0]          ry_o,
  output logic [tta_pkg::DW-1:0] dx_o,
  output logic [tta_pkg::DW-1:0] dy_o,
  output logic [QW-1:0]          qx_o,
  output logic [QW-1:0]          qy_o
);
  import tta_pkg::*;

  logic [XW-1:0] tx, ty, rx_d, ry_d;
  logic [QW-1:0] qx_d, qy_d;

  // trial subtract of the shifted divisor
  always_comb begin
    tx   = XW'(dx_i) << BIT;
    ty   = XW'(dy_i) << BIT;
    rx_d = rx_i;
    ry_d = ry_i;
    qx_d = qx_i;
    qy_d = qy_i;
    if (rx_i >= tx) begin
      rx_d      = rx_i - tx;
      qx_d[BIT] = 1'b1;
    end
    if (ry_i >= ty) begin
      ry_d      = ry_i - ty;
      qy_d[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      rx_o   <= rx_d;
      ry_o   <= ry_d;
      dx_o   <= dx_i;
      dy_o   <= dy_i;
      qx_o   <= qx_d;
      qy_o   <= qy_d;
    end
  end

endmodule

// ----- design/tta_back.sv -----
// last stage: clamp or wrap each axis and build the response
module tta_back #(
  parameter int XW = 45,
  parameter int QW = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  tta_pkg::tta_side_t side_i,
  input  tta_pkg::tta_cfg_t  cfg_i,
  input  logic [XW-1:0]      rx_i,
  input  logic [XW-1:0]      ry_i,
  input  logic [QW-1:0]      qx_i,
  input  logic [QW-1:0]      qy_i,
  output logic               valid_o,
  output tta_pkg::tta_rsp_t  rsp_o
);
  import tta_pkg::*;

  function automatic logic [SW-1:0] lane(logic [QW-1:0] q, logic [XW-1:0] r,
                                         logic [SW-1:0] size, logic neg,
                                         logic mode, logic op);
    logic [SW-1:0] last;
    logic [SW-1:0] rl;
    logic [SW-1:0] res;
    last = size - 1'b1;
    rl   = r[SW-1:0];
    if (op == OP_CUBE) begin
      res = (q >= QW'(size)) ? last : q[SW-1:0];
    end else if (mode == MODE_CLAMP) begin
      res = neg ? '0 : ((q != '0) ? last : rl);
    end else begin
      res = (neg && rl != '0) ? size - rl : rl;
    end
    return res;
  endfunction

  logic [SW-1:0] tx, ty;
  tta_rsp_t      rsp_d;

  always_comb begin
    tx = lane(qx_i, rx_i, cfg_i.width, side_i.neg_x, cfg_i.mode_x, side_i.op);
    ty = lane(qy_i, ry_i, cfg_i.height, side_i.neg_y, cfg_i.mode_y, side_i.op);
    rsp_d.cube_face   = (side_i.op == OP_CUBE) ? side_i.face : FACE_POS_X;
    rsp_d.texel_x     = tx[TW-1:0];
    rsp_d.texel_y     = ty[TW-1:0];
    rsp_d.zero_vector = 1'b0;
    if (side_i.op == OP_CUBE && side_i.zero) begin
      rsp_d.cube_face   = FACE_POS_X;
      rsp_d.texel_x     = '0;
      rsp_d.texel_y     = '0;
      rsp_d.zero_vector = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp_o <= rsp_d;
    end
  end

endmodule

// ----- design/texture_texel_address_core.sv -----
// top level of the texture texel address front end
// Usage: a request on in_req_i (valid/ready) is either a flat u,v coordinate
// or a cube direction; each gives exactly one response on out_rsp_o
// (valid/ready) with face, texel x/y and the zero vector flag, in order.
// Texture sizes and address modes are set through the APB port while no
// request is in flight; pready is always high.
// QW = max(13, 36-FRAC_BITS). Two front stages, QW one-bit steps of the
// shared restoring divider (texel quotient for cube faces, wrap remainder
// for flat requests), and the output register. One request is taken every
// cycle unless the receiver stalls.
// When the receiver stalls the whole pipeline holds and in_ready_o drops;
// nothing is lost or repeated, and it resumes on the next ready.
// Reset clears the valid bits and sets sizes 256x256 with clamp addressing.
module texture_texel_address_core #(
  parameter int MAX_SIZE  = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tta_pkg::tta_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tta_pkg::tta_rsp_t out_rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tta_pkg::*;

  localparam int QW = (CW - 1 + SW - FRAC_BITS > SW) ? CW - 1 + SW - FRAC_BITS : SW;
  localparam int XW = DW + QW;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HMODE  = 2'd2;
  localparam logic [1:0] REG_VMODE  = 2'd3;

  logic [SW-1:0] width_q, height_q;
  logic          hmode_q, vmode_q;
  tta_cfg_t      cfg;
  logic          en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SW'(256);
      height_q <= SW'(256);
      hmode_q  <= MODE_CLAMP;
      vmode_q  <= MODE_CLAMP;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_WIDTH:  width_q  <= pwdata[SW-1:0];
        REG_HEIGHT: height_q <= pwdata[SW-1:0];
        REG_HMODE:  hmode_q  <= pwdata[0];
        REG_VMODE:  vmode_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {{(32-SW){1'b0}}, width_q};
      REG_HEIGHT: prdata = {{(32-SW){1'b0}}, height_q};
      REG_HMODE:  prdata = {31'd0, hmode_q};
      REG_VMODE:  prdata = {31'd0, vmode_q};
      default:    prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // effective sizes saturated to 1..MAX_SIZE
  always_comb begin
    cfg.width  = (width_q == '0) ? SW'(1) :
                 ((32'(width_q) > MAX_SIZE) ? SW'(MAX_SIZE) : width_q);
    cfg.height = (height_q == '0) ? SW'(1) :
                 ((32'(height_q) > MAX_SIZE) ? SW'(MAX_SIZE) : height_q);
    cfg.mode_x = hmode_q;
    cfg.mode_y = vmode_q;
  end

  // pipeline advances unless the output register holds an untaken response
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic              vld   [QW+1];
  tta_side_t         side  [QW+1];
  logic [XW-1:0]     rx    [QW+1];
  logic [XW-1:0]     ry    [QW+1];
  logic [DW-1:0]     dx    [QW+1];
  logic [DW-1:0]     dy    [QW+1];
  logic [QW-1:0]     qx    [QW+1];
  logic [QW-1:0]     qy    [QW+1];

  tta_front #(.FRAC_BITS(FRAC_BITS), .XW(XW)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .req_i(in_req_i), .cfg_i(cfg),
    .valid_o(vld[0]), .side_o(side[0]), .nx_o(rx[0]), .ny_o(ry[0]),
    .dx_o(dx[0]), .dy_o(dy[0])
  );
  assign qx[0] = '0;
  assign qy[0] = '0;

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_div
    tta_div_step #(.XW(XW), .QW(QW), .BIT(QW-1-k)) u_step (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(vld[k]), .side_i(side[k]), .rx_i(rx[k]), .ry_i(ry[k]),
      .dx_i(dx[k]), .dy_i(dy[k]), .qx_i(qx[k]), .qy_i(qy[k]),
      .valid_o(vld[k+1]), .side_o(side[k+1]), .rx_o(rx[k+1]), .ry_o(ry[k+1]),
      .dx_o(dx[k+1]), .dy_o(dy[k+1]), .qx_o(qx[k+1]), .qy_o(qy[k+1])
    );
  end

  tta_back #(.XW(XW), .QW(QW)) u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vld[QW]), .side_i(side[QW]), .cfg_i(cfg),
    .rx_i(rx[QW]), .ry_i(ry[QW]), .qx_i(qx[QW]), .qy_i(qy[QW]),
    .valid_o(out_valid_o), .rsp_o(out_rsp_o)
  );

  // a zero direction always reports face zero at texel origin
  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.zero_vector |->
      out_rsp_o.cube_face == FACE_POS_X && out_rsp_o.texel_x == '0 &&
      out_rsp_o.texel_y == '0)
    else $error("zero vector response carries a face or texel");

  // only six faces exist
  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.cube_face <= FACE_POS_Z)
    else $error("cube face out of range");

  // a stalled pipeline keeps its divider valid bits
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> vld[QW] == $past(vld[QW]) && vld[0] == $past(vld[0]))
    else $error("request lost or duplicated during stall");

endmodule
